FILE: src/cfb_pkg.sv
`timescale 1ns / 1ps
package cfb_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_UPPER_LIMIT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIDDLE_LIMIT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_UPPER_DOSE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIDDLE_DOSE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FALLBACK_TGT = 3'd4;

    localparam logic [BYTE_W-1:0] RST_UPPER_LIMIT = 8'd140;
    localparam logic [BYTE_W-1:0] RST_MIDDLE_LIMIT = 8'd120;
    localparam logic [BYTE_W-1:0] RST_UPPER_DOSE = 8'd20;
    localparam logic [BYTE_W-1:0] RST_MIDDLE_DOSE = 8'd10;
    localparam logic [BYTE_W-1:0] RST_FALLBACK_TGT = 8'd10;

    localparam logic [BYTE_W-1:0] CMD_INJECT = 8'h01;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
    localparam logic [BYTE_W-1:0] SEAL_XOR = 8'hAA;
    localparam logic [BYTE_W-1:0] SEAL_ADD = 8'h55;

    localparam logic REQ_FORWARD = 1'b0;
    localparam logic REQ_FALLBACK = 1'b1;

    localparam int unsigned POS_W = 3;
    localparam logic [POS_W-1:0] POS_CMD = 3'd0;
    localparam logic [POS_W-1:0] POS_TARGET = 3'd1;
    localparam logic [POS_W-1:0] POS_DOSE = 3'd2;
    localparam logic [POS_W-1:0] POS_SEQ = 3'd3;
    localparam logic [POS_W-1:0] POS_SEAL = 3'd4;
    localparam logic [POS_W-1:0] POS_CRC = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] target;
        logic [BYTE_W-1:0] dose;
        logic [BYTE_W-1:0] seq;
        logic [BYTE_W-1:0] seal;
    } t_frame;

    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] acc;
        acc = crc ^ data;
        for (int b = 0; b < BYTE_W; b++) begin
            if (acc[BYTE_W-1]) begin
                acc = {acc[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                acc = {acc[BYTE_W-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

endpackage

FILE: src/cfb_front.sv
`timescale 1ns / 1ps
module cfb_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic                                 i_req_type,
    input  logic [cfb_pkg::BYTE_W-1:0]           i_target_id,
    input  logic [cfb_pkg::BYTE_W-1:0]           i_dose_value,
    input  logic [cfb_pkg::BYTE_W-1:0]           i_seal_value,
    input  logic [cfb_pkg::BYTE_W-1:0]           i_pulse_rate,
    input  logic                                 i_cfg_we,
    input  logic [cfb_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [cfb_pkg::BYTE_W-1:0]           i_cfg_wdata,
    output cfb_pkg::t_frame                      o_frame
);

    logic [cfb_pkg::BYTE_W-1:0] r_upper_limit;
    logic [cfb_pkg::BYTE_W-1:0] r_middle_limit;
    logic [cfb_pkg::BYTE_W-1:0] r_upper_dose;
    logic [cfb_pkg::BYTE_W-1:0] r_middle_dose;
    logic [cfb_pkg::BYTE_W-1:0] r_fallback_tgt;
    logic [cfb_pkg::BYTE_W-1:0] r_seq;
    logic [cfb_pkg::BYTE_W-1:0] n_seq;
    logic [cfb_pkg::BYTE_W-1:0] fb_dose;

    assign n_seq = r_seq + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_limit <= cfb_pkg::RST_UPPER_LIMIT;
            r_middle_limit <= cfb_pkg::RST_MIDDLE_LIMIT;
            r_upper_dose <= cfb_pkg::RST_UPPER_DOSE;
            r_middle_dose <= cfb_pkg::RST_MIDDLE_DOSE;
            r_fallback_tgt <= cfb_pkg::RST_FALLBACK_TGT;
            r_seq <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    cfb_pkg::CFG_UPPER_LIMIT: r_upper_limit <= i_cfg_wdata;
                    cfb_pkg::CFG_MIDDLE_LIMIT: r_middle_limit <= i_cfg_wdata;
                    cfb_pkg::CFG_UPPER_DOSE: r_upper_dose <= i_cfg_wdata;
                    cfb_pkg::CFG_MIDDLE_DOSE: r_middle_dose <= i_cfg_wdata;
                    cfb_pkg::CFG_FALLBACK_TGT: r_fallback_tgt <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                r_seq <= n_seq;
            end
        end
    end

    // The upper limit is tested first, so it wins when the limits are out of order.
    always_comb begin
        if (i_pulse_rate > r_upper_limit) begin
            fb_dose = r_upper_dose;
        end else if (i_pulse_rate > r_middle_limit) begin
            fb_dose = r_middle_dose;
        end else begin
            fb_dose = '0;
        end
    end

    always_comb begin
        o_frame.seq = n_seq;
        if (i_req_type == cfb_pkg::REQ_FALLBACK) begin
            o_frame.target = r_fallback_tgt;
            o_frame.dose = fb_dose;
            o_frame.seal = (fb_dose ^ cfb_pkg::SEAL_XOR) + cfb_pkg::SEAL_ADD;
        end else begin
            o_frame.target = i_target_id;
            o_frame.dose = i_dose_value;
            o_frame.seal = i_seal_value;
        end
    end

`ifndef NO_ASSERTIONS
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_cfg_we |=> r_seq == $past(r_seq) + 8'd1)
        else $error("sequence count did not advance on an accepted item");
`endif

endmodule

FILE: src/cfb_queue.sv
`timescale 1ns / 1ps
module cfb_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  cfb_pkg::t_frame i_wdata,
    output logic            o_full,
    input  logic            i_rd,
    output logic            o_empty,
    output cfb_pkg::t_frame o_rdata
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cfb_pkg::t_frame r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_wr = i_wr && !o_full;
    assign do_rd = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == FULL_CNT) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");
`endif

endmodule

FILE: src/cfb_back.sv
`timescale 1ns / 1ps
module cfb_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  cfb_pkg::t_frame            i_q_frame,
    output logic                       o_q_rd,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [cfb_pkg::BYTE_W-1:0] o_tx_byte,
    output logic                       o_last_byte
);

    cfb_pkg::t_frame                r_frame;
    logic                           r_busy;
    logic [cfb_pkg::POS_W-1:0]      r_pos;
    logic [cfb_pkg::BYTE_W-1:0]     r_crc;
    logic                           r_out_valid;
    logic [cfb_pkg::BYTE_W-1:0]     r_out_byte;
    logic                           r_out_last;
    logic                           out_ready;
    logic                           at_crc;
    logic                           take;
    logic [cfb_pkg::BYTE_W-1:0]     cur_byte;

    assign out_ready = !r_out_valid || i_pop;
    assign at_crc = (r_pos == cfb_pkg::POS_CRC);
    assign take = (!r_busy || (out_ready && at_crc)) && !i_q_empty;
    assign o_q_rd = take;

    always_comb begin
        case (r_pos)
            cfb_pkg::POS_CMD: cur_byte = cfb_pkg::CMD_INJECT;
            cfb_pkg::POS_TARGET: cur_byte = r_frame.target;
            cfb_pkg::POS_DOSE: cur_byte = r_frame.dose;
            cfb_pkg::POS_SEQ: cur_byte = r_frame.seq;
            cfb_pkg::POS_SEAL: cur_byte = r_frame.seal;
            default: cur_byte = r_crc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_frame <= i_q_frame;
        end
        if (out_ready) begin
            r_out_byte <= cur_byte;
            r_out_last <= at_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos <= cfb_pkg::POS_CMD;
            r_crc <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_ready) begin
                r_out_valid <= r_busy;
            end
            if (take) begin
                r_busy <= 1'b1;
                r_pos <= cfb_pkg::POS_CMD;
                r_crc <= '0;
            end else if (r_busy && out_ready) begin
                if (at_crc) begin
                    r_busy <= 1'b0;
                    r_pos <= cfb_pkg::POS_CMD;
                end else begin
                    r_pos <= r_pos + 1'b1;
                    r_crc <= cfb_pkg::crc8_byte(r_crc, cur_byte);
                end
            end
        end
    end

    assign o_empty = !r_out_valid;
    assign o_tx_byte = r_out_byte;
    assign o_last_byte = r_out_last;

`ifndef NO_ASSERTIONS
    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_pos == cfb_pkg::POS_CMD)
        else $error("idle serializer away from first byte");
    a_last_from_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && out_ready && at_crc |=> r_out_valid && r_out_last)
        else $error("CRC byte not marked last");
    a_first_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_busy && r_pos == cfb_pkg::POS_CMD && r_crc == '0)
        else $error("new frame did not start cleanly");
`endif

endmodule

FILE: src/command_frame_builder_crc8.sv
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// input     push / full             i_req_type, i_target_id, i_dose_value,
//                                   i_seal_value, i_pulse_rate
// result    empty / pop             o_tx_byte, o_last_byte
// config    i_cfg_we                i_cfg_addr, i_cfg_wdata
//
// Each item yields six result items, one per cycle from the byte serializer
// while pop keeps up with them, so the sustained rate is set by that serializer.
// A result passes through the queue, the serializer frame register and the output register.
// The front classifies an item in the cycle it is accepted and queues it,
// so input and result sides stall independently until the queue fills.
// Reset is synchronous and active low; it clears the queue, the serializer and
// the sequence count and returns the configuration registers to their defaults.
module command_frame_builder_crc8 #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               i_req_type,
    input  logic [cfb_pkg::BYTE_W-1:0]         i_target_id,
    input  logic [cfb_pkg::BYTE_W-1:0]         i_dose_value,
    input  logic [cfb_pkg::BYTE_W-1:0]         i_seal_value,
    input  logic [cfb_pkg::BYTE_W-1:0]         i_pulse_rate,
    output logic                               empty,
    input  logic                               pop,
    output logic [cfb_pkg::BYTE_W-1:0]         o_tx_byte,
    output logic                               o_last_byte,
    input  logic                               i_cfg_we,
    input  logic [cfb_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [cfb_pkg::BYTE_W-1:0]         i_cfg_wdata
);

    cfb_pkg::t_frame front_frame;
    cfb_pkg::t_frame q_frame;
    logic            accept;
    logic            q_full;
    logic            q_empty;
    logic            q_rd;

    assign accept = push && !q_full;
    assign full = q_full;

    cfb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req_type   (i_req_type),
        .i_target_id  (i_target_id),
        .i_dose_value (i_dose_value),
        .i_seal_value (i_seal_value),
        .i_pulse_rate (i_pulse_rate),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_frame      (front_frame)
    );

    cfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_wdata (front_frame),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_rdata (q_frame)
    );

    cfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_frame   (q_frame),
        .o_q_rd      (q_rd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_tx_byte   (o_tx_byte),
        .o_last_byte (o_last_byte)
    );

endmodule
